/* rtl/core/rau_pkg.sv */
// rau_pkg: shared types and codes for the rational arithmetic unit
// operation codes, status codes, sequencer states and default widths
// no dependencies
package rau_pkg;

	localparam int OPERAND_WIDTH_DEF = 32;
	localparam int MAG_W = 32;
	localparam int PROD_W = 64;
	localparam int SHIFT_W = 6;

	typedef enum logic [2:0] {
		FN_ADD = 3'd0,
		FN_SUB = 3'd1,
		FN_MUL = 3'd2,
		FN_DIV = 3'd3,
		FN_EQ  = 3'd4,
		FN_LT  = 3'd5,
		FN_GT  = 3'd6,
		FN_NOP = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DIVZERO = 2'd1,
		ST_DENZERO = 2'd2,
		ST_RSVD    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_MUL_A,
		S_MUL_B,
		S_MUL_C,
		S_COMB,
		S_GCD_GO,
		S_GCD,
		S_DIVN_GO,
		S_DIVN,
		S_DIVD_GO,
		S_DIVD,
		S_DONE
	} state_t;

endpackage

/* rtl/core/rau_req_if.sv */
// rau_req_if: input channel of the rational arithmetic unit
// valid/ready handshake with operation code and two signed fractions
// depends on rau_pkg
interface rau_req_if;
	import rau_pkg::*;

	logic valid;
	logic ready;
	logic [2:0] func;
	logic signed [31:0] a_num;
	logic signed [31:0] a_den;
	logic signed [31:0] b_num;
	logic signed [31:0] b_den;

	modport source(output valid, func, a_num, a_den, b_num, b_den, input ready);
	modport sink(input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

/* rtl/core/rau_rsp_if.sv */
// rau_rsp_if: result channel of the rational arithmetic unit
// valid/ready handshake with reduced fraction, compare flag and status
// depends on rau_pkg
interface rau_rsp_if;
	import rau_pkg::*;

	logic valid;
	logic ready;
	logic signed [63:0] res_num;
	logic [62:0] res_den;
	logic cmp_true;
	logic [1:0] status;

	modport source(output valid, res_num, res_den, cmp_true, status, input ready);
	modport sink(input valid, res_num, res_den, cmp_true, status, output ready);
endinterface

/* rtl/core/rau_gcd.sv */
// rau_gcd: binary gcd of two nonzero 64-bit magnitudes, one step per cycle
// subtract/compare plus shifts, start/done handshake
// depends on rau_pkg
module rau_gcd
	import rau_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [PROD_W-1:0] a,
	input  logic [PROD_W-1:0] b,
	output logic done,
	output logic [PROD_W-1:0] g
);

	logic [PROD_W-1:0] a_q, b_q;
	logic [SHIFT_W-1:0] k_q;
	logic run_q;
	logic fin;
	logic [PROD_W-1:0] diff_ab, diff_ba;

	assign diff_ab = a_q - b_q;
	assign diff_ba = b_q - a_q;
	assign fin = (a_q == '0) || (b_q == '0);
	assign g = ((b_q == '0) ? a_q : b_q) << k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && fin) begin
				run_q <= 1'b0;
				done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			k_q <= '0;
		end else if (run_q && !fin) begin
			if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q >= b_q) begin
				a_q <= diff_ab >> 1;
			end else begin
				b_q <= diff_ba >> 1;
			end
		end
	end

endmodule

/* rtl/core/rau_div.sv */
// rau_div: restoring divider, 64-bit unsigned, one quotient bit per cycle
// used twice per item to divide numerator and denominator by the gcd
// depends on rau_pkg
module rau_div
	import rau_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [PROD_W-1:0] divisor,
	output logic done,
	output logic [PROD_W-1:0] quotient
);

	logic [PROD_W-1:0] rem_q;
	logic [PROD_W-1:0] quo_q, dsr_q;
	logic [SHIFT_W-1:0] cnt_q;
	logic run_q;
	logic [PROD_W:0] trial, shifted;

	assign shifted = {rem_q, quo_q[PROD_W-1]};
	assign trial = shifted - {1'b0, dsr_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == '1) begin
				run_q <= 1'b0;
				done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (!trial[PROD_W]) begin
				rem_q <= trial[PROD_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[PROD_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b0};
			end
		end
	end

endmodule

/* rtl/core/rational_arithmetic_unit.sv */
// Rational arithmetic unit: one item at a time, not ready while an item is in work.
// The NOP code and early results go from S_CHK straight to S_DONE. Compares and
// arithmetic use the shared 32x32 multiplier, which forms the cross products in
// S_MUL_A, S_MUL_B and S_MUL_C, and then S_COMB; arithmetic with a nonzero result
// goes on to the binary gcd and two restoring divisions, which set the latency.
// A finished result sits in an output register, so the next item is taken while it
// waits. Depends on rau_pkg, rau_req_if, rau_rsp_if, rau_gcd and rau_div.
module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)(
	input  logic clk,
	input  logic arst_n,
	rau_req_if.sink req,
	rau_rsp_if.source rsp
);

	state_t state_q, state_d;

	func_t func_q;
	logic an_neg_q, bn_neg_q;
	logic [MAG_W-1:0] an_q, ad_q, bn_q, bd_q;
	logic den_zero_q;
	logic [PROD_W-1:0] p0_q, p1_q, p2_q;
	logic [PROD_W-1:0] num_q, den_q, g_q, rn_q;
	logic neg_q;

	logic signed [63:0] r_num_q;
	logic [62:0] r_den_q;
	logic r_cmp_q;
	status_t r_status_q;
	logic out_valid_q;

	logic gcd_start, gcd_done, div_start, div_done;
	logic [PROD_W-1:0] gcd_g, div_quo, div_dividend;

	function automatic logic [MAG_W:0] take(input logic [31:0] raw);
		logic [OPERAND_WIDTH-1:0] x;
		logic [OPERAND_WIDTH-1:0] m;
		x = raw[OPERAND_WIDTH-1:0];
		m = x[OPERAND_WIDTH-1] ? (~x + 1'b1) : x;
		return {x[OPERAND_WIDTH-1], MAG_W'(m)};
	endfunction

	logic [MAG_W:0] an_t, ad_t, bn_t, bd_t;
	logic is_cmp, acc;

	assign an_t = take(req.a_num);
	assign ad_t = take(req.a_den);
	assign bn_t = take(req.b_num);
	assign bd_t = take(req.b_den);
	assign is_cmp = (req.func == FN_EQ) || (req.func == FN_LT) || (req.func == FN_GT);
	assign req.ready = (state_q == S_IDLE);
	assign acc = req.valid && req.ready;

	// shared multiplier
	logic [MAG_W-1:0] mx, my;
	logic [PROD_W-1:0] prod;
	assign prod = PROD_W'(mx) * PROD_W'(my);

	always_comb begin
		mx = ad_q;
		my = bd_q;
		case (state_q)
			S_MUL_A: begin
				mx = an_q;
				my = (func_q == FN_MUL) ? bn_q : bd_q;
			end
			S_MUL_B: begin
				if (func_q == FN_MUL) begin
					mx = ad_q;
					my = bd_q;
				end else begin
					mx = ad_q;
					my = bn_q;
				end
			end
			default: begin
				mx = ad_q;
				my = bd_q;
			end
		endcase
	end

	// combine step
	logic x_neg, y_neg;
	logic [PROD_W:0] sub_xy, sub_yx;
	logic [PROD_W-1:0] c_mag, c_den;
	logic c_neg, lt, gt, eq, cmp_bit;

	assign x_neg = an_q != '0 && an_neg_q && p0_q != '0;
	assign y_neg = ((func_q == FN_SUB) ? !bn_neg_q : bn_neg_q) && p1_q != '0;
	assign sub_xy = {1'b0, p0_q} - {1'b0, p1_q};
	assign sub_yx = {1'b0, p1_q} - {1'b0, p0_q};

	always_comb begin
		eq = 1'b0;
		lt = 1'b0;
		if ((an_neg_q && p0_q != '0) != (bn_neg_q && p1_q != '0)) begin
			lt = an_neg_q && p0_q != '0;
		end else if (p0_q == p1_q) begin
			eq = 1'b1;
		end else if (!(an_neg_q && p0_q != '0)) begin
			lt = sub_xy[PROD_W];
		end else begin
			lt = !sub_xy[PROD_W];
		end
		gt = !lt && !eq;
		case (func_q)
			FN_EQ: cmp_bit = eq;
			FN_LT: cmp_bit = lt;
			default: cmp_bit = gt;
		endcase
	end

	always_comb begin
		c_mag = p0_q;
		c_neg = an_neg_q ^ bn_neg_q;
		c_den = p1_q;
		if (func_q == FN_ADD || func_q == FN_SUB) begin
			c_den = p2_q;
			if (x_neg == y_neg) begin
				c_mag = p0_q + p1_q;
				c_neg = x_neg;
			end else if (!sub_xy[PROD_W]) begin
				c_mag = sub_xy[PROD_W-1:0];
				c_neg = x_neg;
			end else begin
				c_mag = sub_yx[PROD_W-1:0];
				c_neg = y_neg;
			end
		end
	end

	// early decisions
	logic chk_cmp, chk_nop;
	assign chk_cmp = (func_q == FN_EQ) || (func_q == FN_LT) || (func_q == FN_GT);
	assign chk_nop = (func_q == FN_NOP);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (acc) state_d = S_CHK;
			S_CHK: begin
				if (chk_nop) state_d = S_DONE;
				else if (chk_cmp) state_d = S_MUL_A;
				else if (den_zero_q) state_d = S_DONE;
				else if (func_q == FN_DIV && (an_q == '0 || bn_q == '0)) state_d = S_DONE;
				else state_d = S_MUL_A;
			end
			S_MUL_A: state_d = S_MUL_B;
			S_MUL_B: state_d = S_MUL_C;
			S_MUL_C: state_d = S_COMB;
			S_COMB: begin
				if (chk_cmp || c_mag == '0) state_d = S_DONE;
				else state_d = S_GCD_GO;
			end
			S_GCD_GO: state_d = S_GCD;
			S_GCD: if (gcd_done) state_d = S_DIVN_GO;
			S_DIVN_GO: state_d = S_DIVN;
			S_DIVN: if (div_done) state_d = S_DIVD_GO;
			S_DIVD_GO: state_d = S_DIVD;
			S_DIVD: if (div_done) state_d = S_DONE;
			S_DONE: if (!out_valid_q || rsp.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		gcd_start = (state_q == S_GCD_GO);
		div_start = (state_q == S_DIVN_GO) || (state_q == S_DIVD_GO);
		div_dividend = (state_q == S_DIVN_GO) ? num_q : den_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			func_q <= func_t'(req.func);
			den_zero_q <= (ad_t[MAG_W-1:0] == '0) || (bd_t[MAG_W-1:0] == '0);
			if (is_cmp && ad_t[MAG_W-1:0] == '0) begin
				an_q <= '0;
				an_neg_q <= 1'b0;
				ad_q <= MAG_W'(1);
			end else begin
				an_q <= an_t[MAG_W-1:0];
				an_neg_q <= an_t[MAG_W] ^ ad_t[MAG_W];
				ad_q <= ad_t[MAG_W-1:0];
			end
			if (is_cmp && bd_t[MAG_W-1:0] == '0) begin
				bn_q <= '0;
				bn_neg_q <= 1'b0;
				bd_q <= MAG_W'(1);
			end else begin
				bn_q <= bn_t[MAG_W-1:0];
				bn_neg_q <= bn_t[MAG_W] ^ bd_t[MAG_W];
				bd_q <= bd_t[MAG_W-1:0];
			end
		end
		case (state_q)
			S_CHK: begin
				r_num_q <= '0;
				r_den_q <= '0;
				r_cmp_q <= 1'b0;
				r_status_q <= ST_OK;
				if (!chk_nop && !chk_cmp) begin
					if (den_zero_q) r_status_q <= ST_DENZERO;
					else if (func_q == FN_DIV && an_q == '0) r_den_q <= 63'd1;
					else if (func_q == FN_DIV && bn_q == '0) r_status_q <= ST_DIVZERO;
				end
			end
			S_MUL_A: p0_q <= prod;
			S_MUL_B: p1_q <= prod;
			S_MUL_C: p2_q <= prod;
			S_COMB: begin
				if (chk_cmp) begin
					r_cmp_q <= cmp_bit;
				end else if (c_mag == '0) begin
					r_den_q <= 63'd1;
				end
				num_q <= c_mag;
				den_q <= c_den;
				neg_q <= c_neg;
			end
			S_GCD: if (gcd_done) g_q <= gcd_g;
			S_DIVN: if (div_done) rn_q <= div_quo;
			S_DIVD: begin
				if (div_done) begin
					r_num_q <= neg_q ? (~rn_q + 1'b1) : rn_q;
					r_den_q <= div_quo[62:0];
				end
			end
			default: ;
		endcase
		if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
			rsp.res_num <= r_num_q;
			rsp.res_den <= r_den_q;
			rsp.cmp_true <= r_cmp_q;
			rsp.status <= r_status_q;
		end
	end

	assign rsp.valid = out_valid_q;

	rau_gcd u_gcd (
		.clk(clk),
		.arst_n(arst_n),
		.start(gcd_start),
		.a(num_q),
		.b(den_q),
		.done(gcd_done),
		.g(gcd_g)
	);

	rau_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(g_q),
		.done(div_done),
		.quotient(div_quo)
	);

endmodule

/* rtl/core/rau_checker.sv */
// rau_checker: port-level assertions for the rational arithmetic unit
// bound to rational_arithmetic_unit; depends on rau_pkg
module rau_checker
	import rau_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic signed [63:0] res_num,
	input logic [62:0] res_den,
	input logic cmp_true,
	input logic [1:0] status
);

	// a result offered and not taken stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before transfer");

	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && cmp_true |-> res_num == '0 && res_den == '0 && status == ST_OK)
		else $error("compare result carries a fraction");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> res_num == '0 && res_den == '0 && !cmp_true)
		else $error("error result carries a value");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status != ST_RSVD)
		else $error("reserved status code");

	a_zden: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && res_den == '0 |-> res_num == '0)
		else $error("nonzero numerator over zero denominator");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.res_num(rsp.res_num),
	.res_den(rsp.res_den),
	.cmp_true(rsp.cmp_true),
	.status(rsp.status)
);

/* tb/sv/rational_arithmetic_unit_tb.sv */
// rational_arithmetic_unit_tb: self-checking bench for the rational arithmetic unit
// directed table then random operands, checked against an exact sign/magnitude predictor
// depends on rau_pkg, rau_req_if, rau_rsp_if and rational_arithmetic_unit
module rational_arithmetic_unit_tb;
	import rau_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;
	localparam int N_RANDOM = 1930;

	typedef struct packed {
		logic signed [63:0] num;
		logic [62:0] den;
		logic cmp;
		logic [1:0] st;
	} frac_res_t;

	typedef struct {
		func_t fn;
		logic signed [31:0] an, ad, bn, bd;
		logic known;
		frac_res_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	rau_req_if req();
	rau_rsp_if rsp();

	rational_arithmetic_unit dut(.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source));

	frac_res_t pending_q[$];
	int errors = 0;
	int idle_cnt = 0;
	int send_gap = 0;
	int recv_stall = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] mag32(logic signed [31:0] v);
		return v < 0 ? 64'(-64'(v)) : 64'(v);
	endfunction

	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic frac_res_t reduce_frac(func_t fn, logic signed [31:0] an,
			logic signed [31:0] ad, logic signed [31:0] bn, logic signed [31:0] bd);
		frac_res_t r;
		logic signed [65:0] lhs, rhs, n, d;
		logic [65:0] nm, dm, g;
		r = '0;
		if (fn == FN_NOP) return r;
		if (fn inside {FN_EQ, FN_LT, FN_GT}) begin
			if (ad == 0) begin an = 0; ad = 1; end
			if (bd == 0) begin bn = 0; bd = 1; end
			lhs = 66'(an) * 66'(bd) * (bd < 0 ? -1 : 1) * (ad < 0 ? -1 : 1);
			rhs = 66'(bn) * 66'(ad) * (ad < 0 ? -1 : 1) * (bd < 0 ? -1 : 1);
			r.cmp = fn == FN_EQ ? lhs == rhs : fn == FN_LT ? lhs < rhs : lhs > rhs;
			return r;
		end
		if (ad == 0 || bd == 0) begin r.st = ST_DENZERO; return r; end
		case (fn)
			FN_ADD: begin n = 66'(an) * 66'(bd) + 66'(ad) * 66'(bn); d = 66'(ad) * 66'(bd); end
			FN_SUB: begin n = 66'(an) * 66'(bd) - 66'(ad) * 66'(bn); d = 66'(ad) * 66'(bd); end
			FN_MUL: begin n = 66'(an) * 66'(bn); d = 66'(ad) * 66'(bd); end
			default: begin
				if (an == 0) begin r.den = 1; return r; end
				if (bn == 0) begin r.st = ST_DIVZERO; return r; end
				n = 66'(an) * 66'(bd);
				d = 66'(ad) * 66'(bn);
			end
		endcase
		if (n == 0) begin r.den = 1; return r; end
		nm = n < 0 ? -n : n;
		dm = d < 0 ? -d : d;
		g = 66'(gcd64(64'(nm), 64'(dm)));
		nm = nm / g;
		dm = dm / g;
		r.num = ((n < 0) != (d < 0)) ? -64'(nm) : 64'(nm);
		r.den = 63'(dm);
		return r;
	endfunction

	function automatic logic signed [31:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000 + $urandom_range(0, 1);
			1: return 32'sh7fff_ffff - $urandom_range(0, 1);
			2: return 0;
			3, 4: return $signed(32'($urandom_range(0, 40))) - 20;
			5, 6: return $signed(32'($urandom_range(0, 4000))) - 2000;
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic send_item(func_t fn, logic signed [31:0] an, logic signed [31:0] ad,
			logic signed [31:0] bn, logic signed [31:0] bd);
		while (send_gap > 0 && $urandom_range(0, 99) < send_gap) @(posedge clk);
		req.valid <= 1'b1;
		req.func <= fn;
		req.a_num <= an;
		req.a_den <= ad;
		req.b_num <= bn;
		req.b_den <= bd;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		pending_q.push_back(reduce_frac(fn, an, ad, bn, bd));
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) rsp.ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	always @(posedge clk) begin
		frac_res_t got, want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = {rsp.res_num, rsp.res_den, rsp.cmp_true, rsp.status};
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected transfer %h", $time, got);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (got.num !== want.num || got.den !== want.den || got.cmp !== want.cmp
						|| got.st !== want.st) begin
					$display("%0t: mismatch expected %0d/%0d cmp %b st %0d actual %0d/%0d cmp %b st %0d",
						$time, want.num, want.den, want.cmp, want.st,
						got.num, got.den, got.cmp, got.st);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG) begin
			$display("rational_arithmetic_unit_tb NOT OK");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		frac_res_t zr;
		func_t fn;
		req.valid = 1'b0;
		req.func = FN_ADD;
		req.a_num = 0;
		req.a_den = 1;
		req.b_num = 0;
		req.b_den = 1;
		rsp.ready = 1'b0;
		zr = '0;
		rows.push_back('{FN_ADD, 1, 2, 1, 3, 0, zr});
		rows.push_back('{FN_SUB, 1, 2, 1, 2, 1, '{0, 1, 0, ST_OK}});
		rows.push_back('{FN_MUL, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 3, 0, zr});
		rows.push_back('{FN_DIV, 0, 5, 0, 7, 1, '{0, 1, 0, ST_OK}});
		rows.push_back('{FN_DIV, 3, 5, 0, 7, 1, '{0, 0, 0, ST_DIVZERO}});
		rows.push_back('{FN_DIV, 3, -5, 2, -7, 0, zr});
		rows.push_back('{FN_ADD, 3, 0, 2, 7, 1, '{0, 0, 0, ST_DENZERO}});
		rows.push_back('{FN_DIV, 0, 5, 2, 0, 1, '{0, 0, 0, ST_DENZERO}});
		rows.push_back('{FN_EQ, 1, 2, -2, -4, 1, '{0, 0, 1, ST_OK}});
		rows.push_back('{FN_LT, 5, 0, 1, 3, 1, '{0, 0, 1, ST_OK}});
		rows.push_back('{FN_GT, 32'sh8000_0000, 1, 32'sh7fff_ffff, 32'sh8000_0000, 0, zr});
		rows.push_back('{FN_EQ, 3, 0, 0, 0, 1, '{0, 0, 1, ST_OK}});
		rows.push_back('{FN_NOP, 5, 6, 7, 8, 1, zr});
		rows.push_back('{FN_ADD, 32'sh7fff_ffff, 32'sh8000_0001, 32'sh8000_0000, -1, 0, zr});
		rows.push_back('{FN_SUB, -1, 32'sh7fff_ffff, -1, 32'sh7fff_fffe, 0, zr});
		rows.push_back('{FN_MUL, 0, -3, 5, 9, 1, '{0, 1, 0, ST_OK}});
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			row = rows[i];
			if (row.known && reduce_frac(row.fn, row.an, row.ad, row.bn, row.bd) !== row.res)
				$display("%0t: table row %0d disagrees with predictor", $time, i);
			send_item(row.fn, row.an, row.ad, row.bn, row.bd);
			if (row.known) pending_q[$] = row.res;
		end
		wait (pending_q.size() == 0);
		for (int p = 0; p < 3; p++) begin
			send_gap = p == 0 ? 18 : p == 1 ? 63 : 0;
			recv_stall = p == 0 ? 63 : p == 1 ? 18 : 0;
			for (int k = 0; k < N_RANDOM / 3; k++) begin
				fn = func_t'($urandom_range(0, 7));
				send_item(fn, rand_operand(), rand_operand(), rand_operand(), rand_operand());
				if (k == 100) wait (pending_q.size() == 0);
			end
		end
		wait (pending_q.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0) $display("rational_arithmetic_unit_tb OK");
		else $display("rational_arithmetic_unit_tb NOT OK");
		$finish;
	end
endmodule
